### rtl/stt_pkg.sv
package stt_pkg;

    localparam int LINE_BITS = 16;
    localparam int OUT_LINE_BITS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        KIND_STRING = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_WORD   = 2'd3
    } kind_t;

    typedef enum logic [9:0] {
        MODE_IDLE   = 10'b0000000001,
        MODE_DASH   = 10'b0000000010,
        MODE_SLASH  = 10'b0000000100,
        MODE_DOT    = 10'b0000001000,
        MODE_LINE   = 10'b0000010000,
        MODE_BLOCK  = 10'b0000100000,
        MODE_STAR   = 10'b0001000000,
        MODE_STRING = 10'b0010000000,
        MODE_NUMBER = 10'b0100000000,
        MODE_WORD   = 10'b1000000000
    } mode_t;

    typedef struct packed {
        logic space;
        logic newline;
        logic dash;
        logic slash;
        logic dot;
        logic star;
        logic quote;
        logic digit;
        logic symbol;
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        char_class_t cls;
    } qitem_t;

endpackage

### rtl/script_token_scanner.sv
// Streaming tokenizer for script source text, one byte per word on the input.
// Input channel: ch and end_of_input with in_valid and in_stall. A word is
// taken at a rising edge with in_valid high and in_stall low. A word with
// end_of_input set flushes the token character still held and returns the
// scanner, line counter included, to its reset state; its ch is ignored.
// Output channel: out_ch, token_kind, first_char, last_char and line_number
// with out_valid and out_stall. Each input word gives zero or one output word.
// Throughput is one input word per cycle unless stalled. The front classifies
// the byte and writes it to a two-entry queue; the back pops one entry per
// cycle into its scan state machine and output register. A token character
// reaches the output register as the byte that completes it is popped, since
// each character is held until the following byte shows whether it ends its
// token. While out_stall is high with a valid output word, it holds, the back
// stops popping and in_stall rises once the queue is full; nothing is dropped.
// Reset clears the scan mode, the held character and the line counter; no
// clearing pass is needed and the first word can be taken right after reset.
module script_token_scanner
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        ch,
    input  logic                              end_of_input,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_ch,
    output logic [1:0]                        token_kind,
    output logic                              first_char,
    output logic                              last_char,
    output logic [stt_pkg::OUT_LINE_BITS-1:0] line_number
);

    logic            q_full;
    logic            push;
    stt_pkg::qitem_t push_item;
    logic            pop;
    logic            head_valid;
    stt_pkg::qitem_t head_item;

    stt_front u_front
    (
        .in_valid     (in_valid),
        .ch           (ch),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .push         (push),
        .push_item    (push_item)
    );

    stt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    stt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_ch      (out_ch),
        .token_kind  (token_kind),
        .first_char  (first_char),
        .last_char   (last_char),
        .line_number (line_number)
    );

endmodule

### rtl/stt_front.sv
module stt_front
(
    input  logic            in_valid,
    input  logic [7:0]      ch,
    input  logic            end_of_input,
    input  logic            q_full,
    output logic            in_stall,
    output logic            push,
    output stt_pkg::qitem_t push_item
);

    stt_pkg::char_class_t cls;

    always_comb
    begin
        cls.space   = (ch == stt_pkg::CH_SPACE) ||
                      ((ch >= stt_pkg::CH_TAB) && (ch <= stt_pkg::CH_CR));
        cls.newline = (ch == stt_pkg::CH_NEWLINE);
        cls.dash    = (ch == stt_pkg::CH_DASH);
        cls.slash   = (ch == stt_pkg::CH_SLASH);
        cls.dot     = (ch == stt_pkg::CH_DOT);
        cls.star    = (ch == stt_pkg::CH_STAR);
        cls.quote   = (ch == stt_pkg::CH_QUOTE);
        cls.digit   = (ch >= stt_pkg::CH_ZERO) && (ch <= stt_pkg::CH_NINE);
        cls.symbol  = (ch != stt_pkg::CH_UNDER) &&
                      (((ch >= 8'd33) && (ch <= 8'd47)) ||
                       ((ch >= 8'd58) && (ch <= 8'd64)) ||
                       ((ch >= 8'd91) && (ch <= 8'd96)) ||
                       ((ch >= 8'd123) && (ch <= 8'd126)));
    end

    assign in_stall      = q_full;
    assign push          = in_valid && !q_full;
    assign push_item.ch  = ch;
    assign push_item.eoi = end_of_input;
    assign push_item.cls = cls;

endmodule

### rtl/stt_queue.sv
module stt_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stt_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output stt_pkg::qitem_t head_item
);

    stt_pkg::qitem_t                    entry_reg [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [stt_pkg::QPTR_BITS-1:0]      wr_ptr_next;
    logic [stt_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [stt_pkg::QPTR_BITS-1:0]      rd_ptr_next;
    logic [stt_pkg::QCNT_BITS-1:0]      count_reg;
    logic [stt_pkg::QCNT_BITS-1:0]      count_next;
    logic                               do_pop;

    localparam logic [stt_pkg::QPTR_BITS-1:0] LAST_PTR =
        stt_pkg::QPTR_BITS'(stt_pkg::QUEUE_DEPTH - 1);
    localparam logic [stt_pkg::QCNT_BITS-1:0] FULL_COUNT =
        stt_pkg::QCNT_BITS'(stt_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/stt_back.sv
module stt_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  stt_pkg::qitem_t                    head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_ch,
    output logic [1:0]                         token_kind,
    output logic                               first_char,
    output logic                               last_char,
    output logic [stt_pkg::OUT_LINE_BITS-1:0]  line_number
);

    stt_pkg::mode_t                  mode_reg;
    stt_pkg::mode_t                  mode_next;
    logic [7:0]                      held_char_reg;
    logic [7:0]                      held_char_next;
    logic                            held_valid_reg;
    logic                            held_valid_next;
    stt_pkg::kind_t                  held_kind_reg;
    stt_pkg::kind_t                  held_kind_next;
    logic                            held_first_reg;
    logic                            held_first_next;
    logic                            held_known_last_reg;
    logic                            held_known_last_next;
    logic [stt_pkg::LINE_BITS-1:0]   line_count_reg;
    logic [stt_pkg::LINE_BITS-1:0]   line_count_next;

    logic                            out_valid_reg;
    logic [7:0]                      out_ch_reg;
    stt_pkg::kind_t                  out_kind_reg;
    logic                            out_first_reg;
    logic                            out_last_reg;
    logic [stt_pkg::OUT_LINE_BITS-1:0] out_line_reg;

    logic                            step;
    logic                            emit;
    logic [7:0]                      e_ch;
    stt_pkg::kind_t                  e_kind;
    logic                            e_first;
    logic                            e_last;
    logic                            line_inc;
    logic                            line_clear;
    logic                            do_start;
    logic                            cont;
    logic [7:0]                      b;
    stt_pkg::char_class_t            c;
    logic [stt_pkg::LINE_BITS+stt_pkg::OUT_LINE_BITS-1:0] line_ext;

    assign step = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = step;
    assign b    = head_item.ch;
    assign c    = head_item.cls;

    always_comb
    begin
        mode_next            = mode_reg;
        held_char_next       = held_char_reg;
        held_valid_next      = held_valid_reg;
        held_kind_next       = held_kind_reg;
        held_first_next      = held_first_reg;
        held_known_last_next = held_known_last_reg;
        emit                 = 1'b0;
        e_ch                 = held_char_reg;
        e_kind               = held_kind_reg;
        e_first              = held_first_reg;
        e_last               = held_known_last_reg;
        line_inc             = 1'b0;
        line_clear           = 1'b0;
        do_start             = 1'b0;
        cont                 = 1'b0;

        if (head_item.eoi)
        begin
            if (held_valid_reg)
            begin
                emit   = 1'b1;
                e_last = 1'b1;
            end
            else if (mode_reg == stt_pkg::MODE_DASH || mode_reg == stt_pkg::MODE_SLASH ||
                     mode_reg == stt_pkg::MODE_DOT)
            begin
                emit    = 1'b1;
                e_kind  = stt_pkg::KIND_SYMBOL;
                e_first = 1'b1;
                e_last  = 1'b1;
                e_ch    = (mode_reg == stt_pkg::MODE_DASH)  ? stt_pkg::CH_DASH :
                          (mode_reg == stt_pkg::MODE_SLASH) ? stt_pkg::CH_SLASH :
                                                              stt_pkg::CH_DOT;
            end
            mode_next            = stt_pkg::MODE_IDLE;
            held_char_next       = '0;
            held_valid_next      = 1'b0;
            held_kind_next       = stt_pkg::KIND_STRING;
            held_first_next      = 1'b0;
            held_known_last_next = 1'b0;
            line_clear           = 1'b1;
        end
        else
        begin
            case (mode_reg)
                stt_pkg::MODE_DASH,
                stt_pkg::MODE_DOT:
                begin
                    e_ch = (mode_reg == stt_pkg::MODE_DASH) ? stt_pkg::CH_DASH
                                                            : stt_pkg::CH_DOT;
                    if (mode_reg == stt_pkg::MODE_DASH && c.dash)
                    begin
                        mode_next = stt_pkg::MODE_LINE;
                    end
                    else if (c.digit)
                    begin
                        emit                 = 1'b1;
                        e_kind               = stt_pkg::KIND_NUMBER;
                        e_first              = 1'b1;
                        e_last               = 1'b0;
                        held_char_next       = b;
                        held_kind_next       = stt_pkg::KIND_NUMBER;
                        held_first_next      = 1'b0;
                        held_known_last_next = 1'b0;
                        held_valid_next      = 1'b1;
                        mode_next            = stt_pkg::MODE_NUMBER;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        e_kind   = stt_pkg::KIND_SYMBOL;
                        e_first  = 1'b1;
                        e_last   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_SLASH:
                begin
                    if (c.star)
                    begin
                        mode_next = stt_pkg::MODE_BLOCK;
                    end
                    else if (c.slash)
                    begin
                        mode_next = stt_pkg::MODE_LINE;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        e_ch     = stt_pkg::CH_SLASH;
                        e_kind   = stt_pkg::KIND_SYMBOL;
                        e_first  = 1'b1;
                        e_last   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_LINE:
                begin
                    if (c.newline)
                    begin
                        line_inc  = 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_BLOCK:
                begin
                    if (c.star)
                    begin
                        mode_next = stt_pkg::MODE_STAR;
                    end
                    else if (c.newline)
                    begin
                        line_inc = 1'b1;
                    end
                end
                stt_pkg::MODE_STAR:
                begin
                    if (c.slash)
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                    else if (!c.star)
                    begin
                        line_inc  = c.newline;
                        mode_next = stt_pkg::MODE_BLOCK;
                    end
                end
                stt_pkg::MODE_STRING:
                begin
                    emit                 = held_valid_reg;
                    held_char_next       = b;
                    held_kind_next       = stt_pkg::KIND_STRING;
                    held_first_next      = 1'b0;
                    held_known_last_next = c.quote;
                    held_valid_next      = 1'b1;
                    if (c.quote)
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_NUMBER,
                stt_pkg::MODE_WORD:
                begin
                    if (mode_reg == stt_pkg::MODE_NUMBER)
                    begin
                        cont = c.digit || c.dot;
                    end
                    else
                    begin
                        cont = !c.space && !c.symbol;
                    end
                    emit            = held_valid_reg;
                    e_last          = held_known_last_reg || !cont;
                    held_valid_next = 1'b0;
                    if (cont)
                    begin
                        held_char_next       = b;
                        held_kind_next       = held_kind_reg;
                        held_first_next      = 1'b0;
                        held_known_last_next = 1'b0;
                        held_valid_next      = 1'b1;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    emit            = held_valid_reg;
                    e_last          = 1'b1;
                    held_valid_next = 1'b0;
                    do_start        = 1'b1;
                end
            endcase

            if (do_start)
            begin
                held_first_next      = 1'b1;
                held_known_last_next = 1'b0;
                held_char_next       = b;
                if (c.space)
                begin
                    line_inc  = c.newline;
                    mode_next = stt_pkg::MODE_IDLE;
                end
                else if (c.dash)
                begin
                    mode_next = stt_pkg::MODE_DASH;
                end
                else if (c.slash)
                begin
                    mode_next = stt_pkg::MODE_SLASH;
                end
                else if (c.dot)
                begin
                    mode_next = stt_pkg::MODE_DOT;
                end
                else if (c.quote)
                begin
                    held_kind_next  = stt_pkg::KIND_STRING;
                    held_valid_next = 1'b1;
                    mode_next       = stt_pkg::MODE_STRING;
                end
                else if (c.digit)
                begin
                    held_kind_next  = stt_pkg::KIND_NUMBER;
                    held_valid_next = 1'b1;
                    mode_next       = stt_pkg::MODE_NUMBER;
                end
                else if (c.symbol)
                begin
                    held_kind_next       = stt_pkg::KIND_SYMBOL;
                    held_known_last_next = 1'b1;
                    held_valid_next      = 1'b1;
                    mode_next            = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    held_kind_next  = stt_pkg::KIND_WORD;
                    held_valid_next = 1'b1;
                    mode_next       = stt_pkg::MODE_WORD;
                end
            end
        end
    end

    always_comb
    begin
        line_count_next = line_count_reg;
        if (line_clear)
        begin
            line_count_next = '0;
        end
        else if (line_inc && (line_count_reg != '1))
        begin
            line_count_next = line_count_reg + 1'b1;
        end
    end

    assign line_ext = {{stt_pkg::OUT_LINE_BITS{1'b0}}, line_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= stt_pkg::MODE_IDLE;
            held_valid_reg      <= 1'b0;
            held_char_reg       <= '0;
            held_kind_reg       <= stt_pkg::KIND_STRING;
            held_first_reg      <= 1'b0;
            held_known_last_reg <= 1'b0;
            line_count_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                mode_reg            <= mode_next;
                held_valid_reg      <= held_valid_next;
                held_char_reg       <= held_char_next;
                held_kind_reg       <= held_kind_next;
                held_first_reg      <= held_first_next;
                held_known_last_reg <= held_known_last_next;
                line_count_reg      <= line_count_next;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_ch_reg    <= e_ch;
            out_kind_reg  <= e_kind;
            out_first_reg <= e_first;
            out_last_reg  <= e_last;
            out_line_reg  <= line_ext[stt_pkg::OUT_LINE_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_ch      = out_ch_reg;
    assign token_kind  = out_kind_reg;
    assign first_char  = out_first_reg;
    assign last_char   = out_last_reg;
    assign line_number = out_line_reg;

endmodule

### tb/sv/script_token_scanner_test.sv
module script_token_scanner_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int PHASE_WORDS    = 635;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [7:0]               value;
        kind_t                    kind;
        logic                     first;
        logic                     last;
        logic [OUT_LINE_BITS-1:0] line;
    } token_char_t;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_TYPED
    } row_check_t;

    typedef struct packed {
        logic [7:0]  c;
        logic        eoi;
        row_check_t  check;
        token_char_t want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [7:0]               ch = 8'h00;
    logic                     end_of_input = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [7:0]               out_ch;
    logic [1:0]               token_kind;
    logic                     first_char;
    logic                     last_char;
    logic [OUT_LINE_BITS-1:0] line_number;

    script_token_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_ch       (out_ch),
        .token_kind   (token_kind),
        .first_char   (first_char),
        .last_char    (last_char),
        .line_number  (line_number)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Scanner state kept by the testbench.
    mode_t                scan_state;
    logic [7:0]           held_value;
    kind_t                held_kind;
    logic                 held_first;
    logic                 held_ends;
    logic                 held_ok;
    logic [LINE_BITS-1:0] lines;

    token_char_t expected_chars[$];
    stim_row_t   directed_rows[$];

    int items_sent = 0;
    int chars_checked = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_asked = 0;
    int hold_off_done = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    function automatic token_char_t token_of(input logic [7:0] value, input kind_t kind,
                                             input logic first, input logic last,
                                             input logic [OUT_LINE_BITS-1:0] line);
        token_char_t t;
        t.value = value;
        t.kind  = kind;
        t.first = first;
        t.last  = last;
        t.line  = line;
        return t;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_punct(input logic [7:0] b);
        return b != CH_UNDER && ((b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
                                 (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126));
    endfunction

    function automatic void scanner_clear();
        scan_state = MODE_IDLE;
        held_value = 8'h00;
        held_kind  = KIND_STRING;
        held_first = 1'b0;
        held_ends  = 1'b0;
        held_ok    = 1'b0;
        lines      = '0;
    endfunction

    function automatic void count_line();
        if (lines != '1)
            lines = lines + 1'b1;
    endfunction

    function automatic void hold(input logic [7:0] b, input kind_t kind, input logic first,
                                 input logic ends);
        held_value = b;
        held_kind  = kind;
        held_first = first;
        held_ends  = ends;
        held_ok    = 1'b1;
    endfunction

    function automatic bit take_held(input logic last, output token_char_t t);
        t = '0;
        if (!held_ok)
            return 1'b0;
        held_ok = 1'b0;
        t = token_of(held_value, held_kind, held_first, last | held_ends,
                     lines[OUT_LINE_BITS-1:0]);
        return 1'b1;
    endfunction

    // A byte seen between tokens; nothing is held at this point.
    function automatic void open_token(input logic [7:0] b);
        if (is_blank(b))
        begin
            if (b == CH_NEWLINE)
                count_line();
            scan_state = MODE_IDLE;
        end
        else if (b == CH_DASH)
            scan_state = MODE_DASH;
        else if (b == CH_SLASH)
            scan_state = MODE_SLASH;
        else if (b == CH_DOT)
            scan_state = MODE_DOT;
        else if (b == CH_QUOTE)
        begin
            hold(b, KIND_STRING, 1'b1, 1'b0);
            scan_state = MODE_STRING;
        end
        else if (is_digit(b))
        begin
            hold(b, KIND_NUMBER, 1'b1, 1'b0);
            scan_state = MODE_NUMBER;
        end
        else if (is_punct(b))
        begin
            hold(b, KIND_SYMBOL, 1'b1, 1'b1);
            scan_state = MODE_IDLE;
        end
        else
        begin
            hold(b, KIND_WORD, 1'b1, 1'b0);
            scan_state = MODE_WORD;
        end
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic eoi,
                                     output token_char_t t);
        bit got;
        bit more;
        logic [OUT_LINE_BITS-1:0] ln;
        got = 1'b0;
        t = '0;
        ln = lines[OUT_LINE_BITS-1:0];
        if (eoi)
        begin
            if (held_ok)
                got = take_held(1'b1, t);
            else if (scan_state == MODE_DASH)
            begin
                t = token_of(CH_DASH, KIND_SYMBOL, 1'b1, 1'b1, ln);
                got = 1'b1;
            end
            else if (scan_state == MODE_SLASH)
            begin
                t = token_of(CH_SLASH, KIND_SYMBOL, 1'b1, 1'b1, ln);
                got = 1'b1;
            end
            else if (scan_state == MODE_DOT)
            begin
                t = token_of(CH_DOT, KIND_SYMBOL, 1'b1, 1'b1, ln);
                got = 1'b1;
            end
            scanner_clear();
            return got;
        end
        case (scan_state)
            MODE_DASH:
            begin
                if (b == CH_DASH)
                    scan_state = MODE_LINE;
                else if (is_digit(b))
                begin
                    t = token_of(CH_DASH, KIND_NUMBER, 1'b1, 1'b0, ln);
                    got = 1'b1;
                    hold(b, KIND_NUMBER, 1'b0, 1'b0);
                    scan_state = MODE_NUMBER;
                end
                else
                begin
                    t = token_of(CH_DASH, KIND_SYMBOL, 1'b1, 1'b1, ln);
                    got = 1'b1;
                    open_token(b);
                end
            end
            MODE_SLASH:
            begin
                if (b == CH_STAR)
                    scan_state = MODE_BLOCK;
                else if (b == CH_SLASH)
                    scan_state = MODE_LINE;
                else
                begin
                    t = token_of(CH_SLASH, KIND_SYMBOL, 1'b1, 1'b1, ln);
                    got = 1'b1;
                    open_token(b);
                end
            end
            MODE_DOT:
            begin
                if (is_digit(b))
                begin
                    t = token_of(CH_DOT, KIND_NUMBER, 1'b1, 1'b0, ln);
                    got = 1'b1;
                    hold(b, KIND_NUMBER, 1'b0, 1'b0);
                    scan_state = MODE_NUMBER;
                end
                else
                begin
                    t = token_of(CH_DOT, KIND_SYMBOL, 1'b1, 1'b1, ln);
                    got = 1'b1;
                    open_token(b);
                end
            end
            MODE_LINE:
            begin
                if (b == CH_NEWLINE)
                begin
                    count_line();
                    scan_state = MODE_IDLE;
                end
            end
            MODE_BLOCK:
            begin
                if (b == CH_STAR)
                    scan_state = MODE_STAR;
                else if (b == CH_NEWLINE)
                    count_line();
            end
            MODE_STAR:
            begin
                if (b == CH_SLASH)
                    scan_state = MODE_IDLE;
                else if (b != CH_STAR)
                begin
                    if (b == CH_NEWLINE)
                        count_line();
                    scan_state = MODE_BLOCK;
                end
            end
            MODE_STRING:
            begin
                got = take_held(1'b0, t);
                if (b == CH_QUOTE)
                begin
                    hold(b, KIND_STRING, 1'b0, 1'b1);
                    scan_state = MODE_IDLE;
                end
                else
                    hold(b, KIND_STRING, 1'b0, 1'b0);
            end
            MODE_NUMBER:
            begin
                more = is_digit(b) || b == CH_DOT;
                got = take_held(!more, t);
                if (more)
                    hold(b, KIND_NUMBER, 1'b0, 1'b0);
                else
                    open_token(b);
            end
            MODE_WORD:
            begin
                more = !is_blank(b) && !is_punct(b);
                got = take_held(!more, t);
                if (more)
                    hold(b, KIND_WORD, 1'b0, 1'b0);
                else
                    open_token(b);
            end
            default:
            begin
                got = take_held(1'b1, t);
                open_token(b);
            end
        endcase
        return got;
    endfunction

    function automatic void add_row(input logic [7:0] c, input logic eoi,
                                    input row_check_t check = ROW_PREDICTED,
                                    input token_char_t want = '0);
        stim_row_t r;
        r.c     = c;
        r.eoi   = eoi;
        r.check = check;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_char();
        token_char_t w;
        if (expected_chars.size() == 0)
            report_mismatch("out_ch with no word pending", 0, out_ch);
        else
        begin
            w = expected_chars.pop_front();
            chars_checked++;
            if (out_ch !== w.value)
                report_mismatch("out_ch", w.value, out_ch);
            if (token_kind !== w.kind)
                report_mismatch("token_kind", w.kind, token_kind);
            if (first_char !== w.first)
                report_mismatch("first_char", w.first, first_char);
            if (last_char !== w.last)
                report_mismatch("last_char", w.last, last_char);
            if (line_number !== w.line)
                report_mismatch("line_number", w.line, line_number);
        end
    endtask

    task automatic send_word(input logic [7:0] c, input logic eoi,
                             input row_check_t check = ROW_PREDICTED,
                             input token_char_t want = '0);
        token_char_t t;
        bit got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = scan_byte(c, eoi, t);
        items_sent++;
        if (check == ROW_TYPED)
            expected_chars.push_back(want);
        else if (check == ROW_PREDICTED && got)
            expected_chars.push_back(t);
    endtask

    function automatic logic [7:0] blank_byte();
        int n;
        n = $urandom_range(5);
        return (n == 0) ? CH_SPACE : 8'(8 + n);
    endfunction

    function automatic logic [7:0] digit_byte();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] word_byte();
        int r;
        case ($urandom_range(4))
            0: return "a" + 8'($urandom_range(25));
            1: return "A" + 8'($urandom_range(25));
            2: return CH_UNDER;
            3: return 8'($urandom_range(255, 128));
            default:
            begin
                r = $urandom_range(27);
                return (r < 9) ? 8'(r) : (r < 27) ? 8'(r + 5) : 8'd127;
            end
        endcase
    endfunction

    function automatic logic [7:0] punct_byte();
        logic [7:0] b;
        b = 8'($urandom_range(126, 33));
        while (!is_punct(b))
            b = 8'($urandom_range(126, 33));
        return b;
    endfunction

    function automatic logic [7:0] body_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == avoid) ? "x" : b;
    endfunction

    // One fragment of script-like text, mostly well formed, with some noise.
    task automatic send_fragment();
        int n;
        int sel;
        int prefix;
        n = $urandom_range(6, 1);
        sel = $urandom_range(99);
        if (sel < 14)
            repeat (n) send_word(blank_byte(), 1'b0);
        else if (sel < 32)
        begin
            send_word(word_byte(), 1'b0);
            repeat (n - 1)
                send_word(($urandom_range(3) == 0) ? digit_byte() : word_byte(), 1'b0);
        end
        else if (sel < 48)
        begin
            prefix = $urandom_range(3);
            if (prefix == 1)
                send_word(CH_DASH, 1'b0);
            else if (prefix == 2)
                send_word(CH_DOT, 1'b0);
            send_word(digit_byte(), 1'b0);
            repeat (n - 1)
                send_word(($urandom_range(3) == 0) ? CH_DOT : digit_byte(), 1'b0);
        end
        else if (sel < 60)
        begin
            send_word(CH_QUOTE, 1'b0);
            repeat (n - 1)
                send_word(($urandom_range(5) == 0) ? CH_NEWLINE : body_byte(CH_QUOTE), 1'b0);
            if ($urandom_range(7) == 0)
                send_word(8'($urandom_range(255)), 1'b1);
            else
                send_word(CH_QUOTE, 1'b0);
        end
        else if (sel < 72)
            send_word(punct_byte(), 1'b0);
        else if (sel < 80)
        begin
            if ($urandom_range(1) == 0)
            begin
                send_word(CH_DASH, 1'b0);
                send_word(CH_DASH, 1'b0);
            end
            else
            begin
                send_word(CH_SLASH, 1'b0);
                send_word(CH_SLASH, 1'b0);
            end
            repeat (n) send_word(body_byte(CH_NEWLINE), 1'b0);
            send_word(CH_NEWLINE, 1'b0);
        end
        else if (sel < 88)
        begin
            send_word(CH_SLASH, 1'b0);
            send_word(CH_STAR, 1'b0);
            repeat (n)
            begin
                prefix = $urandom_range(9);
                send_word((prefix < 2) ? CH_STAR : (prefix == 2) ? CH_NEWLINE :
                          8'($urandom_range(255)), 1'b0);
            end
            send_word(CH_STAR, 1'b0);
            send_word(CH_SLASH, 1'b0);
        end
        else if (sel < 96)
            send_word(8'($urandom_range(255)), 1'b0);
        else
            send_word(8'($urandom_range(255)), 1'b1);
        if ($urandom_range(1) == 0)
            send_word(blank_byte(), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_char();
            if (hold_off_done != hold_off_asked)
            begin
                hold_off_done = hold_off_asked;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int phase_end;
        scanner_clear();

        add_row(8'h21, 1'b0, ROW_SILENT);
        add_row(8'h7E, 1'b0, ROW_TYPED, token_of(8'h21, KIND_SYMBOL, 1'b1, 1'b1, 16'd0));
        add_row(8'hA5, 1'b1, ROW_TYPED, token_of(8'h7E, KIND_SYMBOL, 1'b1, 1'b1, 16'd0));
        add_row(8'h00, 1'b0, ROW_SILENT);
        add_row(8'hFF, 1'b0, ROW_TYPED, token_of(8'h00, KIND_WORD, 1'b1, 1'b0, 16'd0));
        add_row(CH_NEWLINE, 1'b0, ROW_TYPED, token_of(8'hFF, KIND_WORD, 1'b0, 1'b1, 16'd0));
        add_row(CH_DASH, 1'b0);
        add_row("5", 1'b0);
        add_row(CH_DOT, 1'b0);
        add_row("a", 1'b0);
        add_row(CH_SLASH, 1'b0);
        add_row(CH_STAR, 1'b0);
        add_row(CH_NEWLINE, 1'b0);
        add_row(CH_STAR, 1'b0);
        add_row(CH_SLASH, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_NEWLINE, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_DASH, 1'b0);
        add_row(CH_DASH, 1'b0);
        add_row("x", 1'b0);
        add_row(CH_NEWLINE, 1'b0);
        add_row(CH_DOT, 1'b0);
        add_row(CH_UNDER, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(8'h5A, 1'b1);
        add_row(CH_DASH, 1'b0);
        add_row(8'hC3, 1'b1, ROW_TYPED, token_of(CH_DASH, KIND_SYMBOL, 1'b1, 1'b1, 16'd0));

        send_idle_pct = 18;
        recv_idle_pct = 84;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].c, directed_rows[i].eoi, directed_rows[i].check,
                      directed_rows[i].want);

        phase_end = items_sent + PHASE_WORDS;
        while (items_sent < phase_end)
            send_fragment();

        send_idle_pct = 84;
        recv_idle_pct = 18;
        phase_end = items_sent + PHASE_WORDS;
        while (items_sent < phase_end)
            send_fragment();

        // The output side holds off for a long stretch while words keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_asked++;
        phase_end = items_sent + PHASE_WORDS;
        while (items_sent < phase_end)
            send_fragment();

        // Count a line, then show that end of input clears the line counter.
        send_word(8'h00, 1'b1);
        send_word("z", 1'b0);
        send_word(CH_NEWLINE, 1'b0);
        send_word("y", 1'b0);
        send_word(8'h00, 1'b1);
        send_word("q", 1'b0);
        send_word(8'hFF, 1'b1);
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Scanned %0d input words: directed cases and random script text",
                 items_sent);
        $display("under three idle mixes and a long output hold-off; %0d chars checked.",
                 chars_checked);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/script_token_scanner.sv
tb/sv/script_token_scanner_test.sv
